@@ rtl/lat_pkg.sv @@
// shared constants and types for the lru age table
`timescale 1ns / 1ps
package lat_pkg;
    localparam int DEPTH     = 64;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = IDX_W + 1;
    localparam int KEY_BITS  = 64;
    localparam int AGE_BITS  = 16;
    localparam int SIZE_W    = 32;
    localparam int TOT_W     = 38;
    localparam int OP_W      = 3;
    localparam int ST_W      = 2;

    localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 3'd1;
    localparam logic [OP_W-1:0] OP_ERASE  = 3'd2;
    localparam logic [OP_W-1:0] OP_TOUCH  = 3'd3;
    localparam logic [OP_W-1:0] OP_EVICT  = 3'd4;

    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd1;
    localparam logic [ST_W-1:0] ST_ABSENT = 2'd2;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [AGE_BITS-1:0] age;
        logic [SIZE_W-1:0]   size;
    } t_entry;

    typedef struct packed {
        logic                match;
        logic                take_free;
        logic                take_best;
        logic [AGE_BITS-1:0] touched_age;
    } t_eval;
endpackage

@@ rtl/lat_entry_eval.sv @@
// per-entry decisions while the table is scanned
`timescale 1ns / 1ps
module lat_entry_eval
    import lat_pkg::*;
(
    input  t_entry              i_entry,
    input  logic                i_valid,
    input  logic [KEY_BITS-1:0] i_key,
    input  logic                i_free_found,
    input  logic                i_best_found,
    input  logic [AGE_BITS-1:0] i_best_age,
    input  logic [KEY_BITS-1:0] i_best_key,
    output t_eval               o_eval
);
    logic w_match;
    assign w_match = i_valid && (i_entry.key == i_key);

    always_comb begin
        o_eval.match     = w_match;
        o_eval.take_free = !i_valid && !i_free_found;
        // greatest nonzero age, smallest key on a tie
        o_eval.take_best = i_valid && (i_entry.age != '0) &&
            (!i_best_found || (i_entry.age > i_best_age) ||
             ((i_entry.age == i_best_age) && (i_entry.key < i_best_key)));
        if (w_match) begin
            o_eval.touched_age = '0;
        end else if (i_entry.age == AGE_MAX) begin
            o_eval.touched_age = i_entry.age;
        end else begin
            o_eval.touched_age = i_entry.age + AGE_BITS'(1);
        end
    end
endmodule

@@ rtl/lru_age_table.sv @@
// lru age table top level: entry memory, scan sequencer and result register
//
//  channel  dir  tdata (low bit first)                 tuser
//  s        in   entry_key[63:0] entry_age[15:0]       opcode[2:0]
//                entry_size[31:0]
//  m        out  status[1:0] hit age_out[15:0]         -
//                size_out[31:0] victim_key[63:0] total_size[37:0], zero pad
//
// each operation reads every slot of the single entry memory in turn (registered read),
// then commits; a new operation is accepted only in idle, never during a scan or commit.
// a touch writes each aged entry back in the cycle after its read.
// reset clears the valid bits and the running total; the memory is not cleared.
// the commit waits while a previous result is still not taken.
`timescale 1ns / 1ps
module lru_age_table
    import lat_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [111:0] s_axis_tdata,  // entry_key, entry_age, entry_size
    input  logic [2:0]   s_axis_tuser,  // opcode
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [159:0] m_axis_tdata   // status, hit, age_out, size_out, victim_key, total_size
);
    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_COMMIT} t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_rd_vld;
    logic [IDX_W-1:0]    r_rd_idx;
    t_entry              r_rdata;
    t_entry              r_mem [DEPTH];
    logic [DEPTH-1:0]    r_valid;
    logic [TOT_W-1:0]    r_total;

    logic [OP_W-1:0]     r_op;
    logic [KEY_BITS-1:0] r_key;
    logic [AGE_BITS-1:0] r_age;
    logic [SIZE_W-1:0]   r_size;

    logic                r_hit;
    logic [IDX_W-1:0]    r_midx;
    logic [AGE_BITS-1:0] r_mage;
    logic [SIZE_W-1:0]   r_msize;
    logic                r_free_found;
    logic [IDX_W-1:0]    r_fidx;
    logic                r_best_found;
    logic [IDX_W-1:0]    r_bidx;
    logic [AGE_BITS-1:0] r_bage;
    logic [SIZE_W-1:0]   r_bsize;
    logic [KEY_BITS-1:0] r_bkey;

    logic                r_out_valid;
    logic [159:0]        r_out_data;

    t_eval               w_eval;
    logic                w_s_acc;
    logic                w_commit;
    logic                w_we;
    logic [IDX_W-1:0]    w_wa;
    t_entry              w_wd;
    logic [IDX_W-1:0]    w_ins_idx;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_s_acc       = s_axis_tvalid && s_axis_tready;
    assign w_commit      = (r_state == S_COMMIT) && (!r_out_valid || m_axis_tready);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign w_ins_idx     = r_hit ? r_midx : r_fidx;

    lat_entry_eval u_eval (
        .i_entry      (r_rdata),
        .i_valid      (r_valid[r_rd_idx]),
        .i_key        (r_key),
        .i_free_found (r_free_found),
        .i_best_found (r_best_found),
        .i_best_age   (r_bage),
        .i_best_key   (r_bkey),
        .o_eval       (w_eval)
    );

    // memory write: touch write-back during the scan, insert at commit
    always_comb begin
        w_we = 1'b0;
        w_wa = r_rd_idx;
        w_wd = r_rdata;
        if ((r_state == S_SCAN) && r_rd_vld && (r_op == OP_TOUCH) && r_valid[r_rd_idx]) begin
            w_we   = 1'b1;
            w_wd.age = w_eval.touched_age;
        end else if (w_commit && (r_op == OP_INSERT) && (r_hit || r_free_found)) begin
            w_we = 1'b1;
            w_wa = w_ins_idx;
            w_wd = '{key: r_key, age: r_age, size: r_size};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rdata <= r_mem[r_cnt[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_rd_vld    <= 1'b0;
            r_valid     <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && m_axis_tready && !w_commit) begin
                r_out_valid <= 1'b0;
            end
            r_rd_vld <= (r_state == S_SCAN) && (r_cnt < CNT_W'(DEPTH));
            r_rd_idx <= r_cnt[IDX_W-1:0];
            case (r_state)
                S_IDLE: begin
                    if (w_s_acc) begin
                        r_op         <= s_axis_tuser;
                        r_key        <= s_axis_tdata[63:0];
                        r_age        <= s_axis_tdata[79:64];
                        r_size       <= s_axis_tdata[111:80];
                        r_cnt        <= '0;
                        r_hit        <= 1'b0;
                        r_free_found <= 1'b0;
                        r_best_found <= 1'b0;
                        r_state      <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_cnt < CNT_W'(DEPTH)) begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                    if (r_rd_vld) begin
                        if (w_eval.match) begin
                            r_hit   <= 1'b1;
                            r_midx  <= r_rd_idx;
                            r_mage  <= r_rdata.age;
                            r_msize <= r_rdata.size;
                        end
                        if (w_eval.take_free) begin
                            r_free_found <= 1'b1;
                            r_fidx       <= r_rd_idx;
                        end
                        if (w_eval.take_best) begin
                            r_best_found <= 1'b1;
                            r_bidx       <= r_rd_idx;
                            r_bage       <= r_rdata.age;
                            r_bsize      <= r_rdata.size;
                            r_bkey       <= r_rdata.key;
                        end
                        if (r_rd_idx == IDX_W'(DEPTH - 1)) begin
                            r_state <= S_COMMIT;
                        end
                    end
                end
                S_COMMIT: begin
                    if (w_commit) begin
                        logic [ST_W-1:0]     v_st;
                        logic                v_hit;
                        logic [AGE_BITS-1:0] v_age;
                        logic [SIZE_W-1:0]   v_size;
                        logic [KEY_BITS-1:0] v_vkey;
                        logic [TOT_W-1:0]    v_tot;
                        v_st   = ST_OK;
                        v_hit  = r_hit && (r_op <= OP_TOUCH);
                        v_age  = '0;
                        v_size = '0;
                        v_vkey = '0;
                        v_tot  = r_total;
                        case (r_op)
                            OP_INSERT: begin
                                if (r_hit) begin
                                    v_tot = r_total - TOT_W'(r_msize) + TOT_W'(r_size);
                                end else if (r_free_found) begin
                                    v_tot = r_total + TOT_W'(r_size);
                                    r_valid[r_fidx] <= 1'b1;
                                end else begin
                                    v_st = ST_FULL;
                                end
                            end
                            OP_LOOKUP: begin
                                if (r_hit) begin
                                    v_age  = r_mage;
                                    v_size = r_msize;
                                end else begin
                                    v_st = ST_ABSENT;
                                end
                            end
                            OP_ERASE: begin
                                if (r_hit) begin
                                    v_tot = r_total - TOT_W'(r_msize);
                                    r_valid[r_midx] <= 1'b0;
                                end else begin
                                    v_st = ST_ABSENT;
                                end
                            end
                            OP_TOUCH: begin
                                if (!r_hit) begin
                                    v_st = ST_ABSENT;
                                end
                            end
                            OP_EVICT: begin
                                if (r_best_found) begin
                                    v_age  = r_bage;
                                    v_size = r_bsize;
                                    v_vkey = r_bkey;
                                    v_tot  = r_total - TOT_W'(r_bsize);
                                    r_valid[r_bidx] <= 1'b0;
                                end else begin
                                    v_st = ST_ABSENT;
                                end
                            end
                            default: begin
                            end
                        endcase
                        r_total     <= v_tot;
                        r_out_valid <= 1'b1;
                        r_out_data  <= {7'd0, v_tot, v_vkey, v_size, v_age, v_hit, v_st};
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH))
        else $error("scan counter past table depth");
    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_acc |=> (r_state == S_SCAN) && (r_cnt == '0))
        else $error("accepted transfer did not start a scan");
    a_result_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_COMMIT))
        else $error("result loaded outside commit");
    a_commit_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) && r_rd_vld && (r_rd_idx == IDX_W'(DEPTH - 1))
        |=> (r_state == S_COMMIT))
        else $error("scan end did not reach commit");
`endif
endmodule
